@@ design/polyline_curvature_stream_core_defines.svh @@
// Assertion macros shared by the polyline curvature stream design files.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef POLYLINE_CURVATURE_STREAM_CORE_DEFINES_SVH
`define POLYLINE_CURVATURE_STREAM_CORE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define PCS_ASSERT_ALWAYS(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PCS_ASSERT_IMP(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PCS_ASSERT_NXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/pcs_pkg.sv @@
// Shared types and constants of the polyline curvature stream core.
// Used by the front end, back end and top level; depends on nothing else.
`default_nettype none

package pcs_pkg;

  localparam int COORD_W    = 32;
  localparam int CURV_W     = 24;
  localparam int TAN_W      = 16;
  localparam int TAN_FRAC   = 14;
  localparam int SEG_W      = 32;
  localparam int ARC_W      = SEG_W + 1;
  localparam int SQRT_IN_W  = 64;

  localparam int COORD_FRAC_BITS_DEF = 10;
  localparam int CURV_FRAC_BITS_DEF  = 16;
  localparam int JOB_DEPTH_DEF       = 4;
  localparam int RES_DEPTH_DEF       = 4;

  localparam logic [CURV_W-1:0] CURV_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_STEP = 2'd1,
    ST_SINGLE    = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      final_point;
  } point_req_t;

  typedef struct packed {
    logic [CURV_W-1:0] curvature;
    logic              final_result;
    status_e           status;
  } curv_res_t;

  typedef struct packed {
    logic [2*TAN_W-1:0] tan_a;
    logic [2*TAN_W-1:0] tan_b;
    logic [ARC_W-1:0]   arc_step;
    logic               final_result;
    logic               single;
  } job_t;

endpackage

`default_nettype wire

@@ design/pcs_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Standalone unit; uses no package.
`default_nettype none

module pcs_isqrt #(
  parameter int W = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   op_i,
  output logic                done_o,
  output logic [W/2-1:0]      root_o
);

  logic         busy_q;
  logic         done_q;
  logic [W-1:0] v_q;
  logic [W-1:0] res_q;
  logic [W-1:0] one_q;
  logic [W-1:0] trial;
  logic         ge;

  assign trial  = res_q + one_q;
  assign ge     = v_q >= trial;
  assign done_o = done_q;
  assign root_o = res_q[W/2-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (one_q == W'(1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= op_i;
      res_q <= '0;
      one_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + one_q;
      end else begin
        res_q <= res_q >> 1;
      end
      one_q <= one_q >> 2;
    end
  end

endmodule

`default_nettype wire

@@ design/pcs_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Standalone unit; requires the quotient to fit in QW bits.
`default_nettype none

module pcs_div #(
  parameter int NW = 46,
  parameter int DW = 32,
  parameter int QW = 15
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [QW-1:0]      quo_o
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] low_q;
  logic [DW:0]   part;
  logic          ge;

  assign part   = {rem_q, low_q[QW-1]};
  assign ge     = part >= {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DW'(num_i >> QW);
      low_q <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= DW'(part - {1'b0, den_q});
      end else begin
        rem_q <= part[DW-1:0];
      end
      low_q <= {low_q[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ design/pcs_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
// Standalone; takes its assertion macros from the project defines header.
`default_nettype none
`include "polyline_curvature_stream_core_defines.svh"

module pcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q;
  logic [AW-1:0]    rd_ptr_q;
  logic [AW:0]      count_q;
  logic [AW:0]      count_d;
  logic             wr_en;
  logic             rd_en;

  assign full_o  = count_q == (AW+1)'(DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    count_d = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `PCS_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= (AW+1)'(DEPTH), "fifo overfilled")
  `PCS_ASSERT_NXT(a_count_up, clk_i, rst_ni, wr_en && !rd_en, count_q == $past(count_q) + 1'b1, "fifo count did not rise")
  `PCS_ASSERT_NXT(a_count_down, clk_i, rst_ni, rd_en && !wr_en, count_q == $past(count_q) - 1'b1, "fifo count did not fall")

endmodule

`default_nettype wire

@@ design/pcs_front.sv @@
// Front end: accepts points, keeps the recent point history, computes segment
// lengths and unit tangents, and issues curvature jobs. Uses pcs_pkg, pcs_isqrt, pcs_div.
`default_nettype none
`include "polyline_curvature_stream_core_defines.svh"

module pcs_front
  import pcs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire point_req_t point_i,
  output logic            job_push_o,
  output job_t            job_o,
  input  wire logic       job_full_i
);

  localparam logic [3:0] F_IDLE   = 4'd0;
  localparam logic [3:0] F_CLASS  = 4'd1;
  localparam logic [3:0] F_SQA    = 4'd2;
  localparam logic [3:0] F_SQB    = 4'd3;
  localparam logic [3:0] F_SUM    = 4'd4;
  localparam logic [3:0] F_SQRT   = 4'd5;
  localparam logic [3:0] F_TSET   = 4'd6;
  localparam logic [3:0] F_NORM   = 4'd7;
  localparam logic [3:0] F_DIVX   = 4'd8;
  localparam logic [3:0] F_DIVY   = 4'd9;
  localparam logic [3:0] F_TDONE  = 4'd10;
  localparam logic [3:0] F_EMIT1  = 4'd11;
  localparam logic [3:0] F_EMITA  = 4'd12;
  localparam logic [3:0] F_EMITB  = 4'd13;
  localparam logic [3:0] F_SINGLE = 4'd14;

  localparam logic [1:0] PH_SEG   = 2'd0;
  localparam logic [1:0] PH_TPREV = 2'd1;
  localparam logic [1:0] PH_TN    = 2'd2;

  localparam int DIFF_W = COORD_W + 1;
  localparam int QW     = TAN_FRAC + 1;
  localparam int DNW    = COORD_W + TAN_FRAC;

  logic [3:0]               st_q;
  logic [1:0]               n_q;
  logic [1:0]               ph_q;
  logic [COORD_W-1:0]       px_q, py_q, p1x_q, p1y_q, p2x_q, p2y_q;
  logic                     fin_q;
  logic [SEG_W-1:0]         sl0_q, sl1_q, dn_q;
  logic [2*TAN_W-1:0]       ut0_q, ut1_q, tprev_q, tn_q;
  logic [COORD_W-1:0]       a_q, b_q, r_q;
  logic                     sgx_q, sgy_q;
  logic [2*COORD_W-1:0]     sqa_q, sqb_q;
  logic [QW-1:0]            tx_q, ty_q;

  logic [DIFF_W-1:0]        dx1, dy1, dx2, dy2, vx, vy;
  logic                     use_v1;
  logic [2*COORD_W:0]       sum;
  logic                     sum_ovf;
  logic [COORD_W-1:0]       m;
  logic                     in_acc;
  logic                     emit_go;
  logic                     sq_start, sq_done;
  logic [SQRT_IN_W/2-1:0]   sq_root;
  logic                     div_start, div_done;
  logic [DNW-1:0]           div_num;
  logic [QW-1:0]            div_quo;
  logic [TAN_W-1:0]         tx_word, ty_word;

  function automatic logic [COORD_W-1:0] mag33(input logic [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] t;
    t = v[DIFF_W-1] ? (~v + 1'b1) : v;
    return t[COORD_W-1:0];
  endfunction

  assign dx1 = {px_q[COORD_W-1], px_q} - {p1x_q[COORD_W-1], p1x_q};
  assign dy1 = {py_q[COORD_W-1], py_q} - {p1y_q[COORD_W-1], p1y_q};
  assign dx2 = {px_q[COORD_W-1], px_q} - {p2x_q[COORD_W-1], p2x_q};
  assign dy2 = {py_q[COORD_W-1], py_q} - {p2y_q[COORD_W-1], p2y_q};
  assign use_v1 = (n_q == 2'd1) || (ph_q == PH_TN);
  assign vx = use_v1 ? dx1 : dx2;
  assign vy = use_v1 ? dy1 : dy2;
  assign sum = {1'b0, sqa_q} + {1'b0, sqb_q};
  assign sum_ovf = sum[2*COORD_W];
  assign m = a_q | b_q;
  assign in_acc = push && (st_q == F_IDLE);
  assign full = st_q != F_IDLE;
  assign emit_go = (n_q == 2'd1) || !job_full_i;
  assign sq_start = (st_q == F_SUM) && !((ph_q == PH_SEG) && sum_ovf);
  assign div_start = ((st_q == F_SQRT) && sq_done && (ph_q != PH_SEG)) ||
                     ((st_q == F_DIVX) && div_done);
  assign tx_word = sgx_q ? (TAN_W'(0) - TAN_W'(tx_q)) : TAN_W'(tx_q);
  assign ty_word = sgy_q ? (TAN_W'(0) - TAN_W'(ty_q)) : TAN_W'(ty_q);

  always_comb begin
    if (st_q == F_SQRT) begin
      div_num = DNW'({a_q[COORD_W-2:0], TAN_FRAC'(0)}) + DNW'(sq_root >> 1);
    end else begin
      div_num = DNW'({b_q[COORD_W-2:0], TAN_FRAC'(0)}) + DNW'(r_q >> 1);
    end
  end

  pcs_isqrt #(
    .W(SQRT_IN_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .op_i   (sum[2*COORD_W-1:0]),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  pcs_div #(
    .NW(DNW),
    .DW(COORD_W),
    .QW(QW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  ((st_q == F_SQRT) ? sq_root : r_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    job_push_o         = 1'b0;
    job_o.tan_a        = tprev_q;
    job_o.tan_b        = tn_q;
    job_o.arc_step     = ARC_W'(dn_q);
    job_o.final_result = 1'b0;
    job_o.single       = 1'b0;
    unique case (st_q)
      F_EMIT1: begin
        job_push_o     = (n_q != 2'd1) && !job_full_i;
        job_o.tan_a    = (n_q == 2'd3) ? ut1_q : ut0_q;
        job_o.tan_b    = tprev_q;
        job_o.arc_step = (n_q == 2'd3) ? ARC_W'(sl1_q) + ARC_W'(sl0_q) : ARC_W'(sl0_q);
      end
      F_EMITA: begin
        job_push_o     = !job_full_i;
        job_o.tan_a    = (n_q == 2'd1) ? tprev_q : ut0_q;
        job_o.arc_step = (n_q == 2'd1) ? ARC_W'(dn_q) : ARC_W'(sl0_q) + ARC_W'(dn_q);
      end
      F_EMITB: begin
        job_push_o         = !job_full_i;
        job_o.final_result = 1'b1;
      end
      F_SINGLE: begin
        job_push_o         = !job_full_i;
        job_o.final_result = 1'b1;
        job_o.single       = 1'b1;
      end
      default: begin
        job_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
      n_q  <= 2'd0;
      ph_q <= PH_SEG;
    end else begin
      unique case (st_q)
        F_IDLE: begin
          if (in_acc) st_q <= F_CLASS;
        end
        F_CLASS: begin
          if (n_q == 2'd0) begin
            st_q <= fin_q ? F_SINGLE : F_IDLE;
            if (!fin_q) n_q <= 2'd1;
          end else begin
            ph_q <= PH_SEG;
            st_q <= F_SQA;
          end
        end
        F_SQA: st_q <= F_SQB;
        F_SQB: st_q <= F_SUM;
        F_SUM: begin
          if ((ph_q == PH_SEG) && sum_ovf) begin
            ph_q <= PH_TPREV;
            st_q <= F_TSET;
          end else begin
            st_q <= F_SQRT;
          end
        end
        F_SQRT: begin
          if (sq_done) begin
            if (ph_q == PH_SEG) begin
              ph_q <= PH_TPREV;
              st_q <= F_TSET;
            end else begin
              st_q <= F_DIVX;
            end
          end
        end
        F_TSET: begin
          st_q <= ((vx == '0) && (vy == '0)) ? F_TDONE : F_NORM;
        end
        F_NORM: begin
          if (!m[COORD_W-1] && m[COORD_W-2]) st_q <= F_SQA;
        end
        F_DIVX: begin
          if (div_done) st_q <= F_DIVY;
        end
        F_DIVY: begin
          if (div_done) st_q <= F_TDONE;
        end
        F_TDONE: begin
          st_q <= (ph_q == PH_TPREV) ? F_EMIT1 : F_EMITA;
        end
        F_EMIT1: begin
          if (emit_go) begin
            if (fin_q) begin
              if (n_q == 2'd1) begin
                st_q <= F_EMITA;
              end else begin
                ph_q <= PH_TN;
                st_q <= F_TSET;
              end
            end else begin
              n_q  <= (n_q == 2'd3) ? 2'd3 : n_q + 2'd1;
              st_q <= F_IDLE;
            end
          end
        end
        F_EMITA: begin
          if (!job_full_i) st_q <= F_EMITB;
        end
        F_EMITB: begin
          if (!job_full_i) begin
            n_q  <= 2'd0;
            st_q <= F_IDLE;
          end
        end
        F_SINGLE: begin
          if (!job_full_i) st_q <= F_IDLE;
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      F_IDLE: begin
        if (in_acc) begin
          px_q  <= point_i.point_x;
          py_q  <= point_i.point_y;
          fin_q <= point_i.final_point;
        end
      end
      F_CLASS: begin
        if (n_q == 2'd0) begin
          p1x_q <= px_q;
          p1y_q <= py_q;
        end else begin
          a_q <= mag33(dx1);
          b_q <= mag33(dy1);
        end
      end
      F_SQA: sqa_q <= a_q * a_q;
      F_SQB: sqb_q <= b_q * b_q;
      F_SUM: begin
        if ((ph_q == PH_SEG) && sum_ovf) dn_q <= '1;
      end
      F_SQRT: begin
        if (sq_done) begin
          if (ph_q == PH_SEG) dn_q <= sq_root;
          else r_q <= sq_root;
        end
      end
      F_TSET: begin
        a_q   <= mag33(vx);
        b_q   <= mag33(vy);
        sgx_q <= vx[DIFF_W-1];
        sgy_q <= vy[DIFF_W-1];
        tx_q  <= '0;
        ty_q  <= '0;
      end
      F_NORM: begin
        if (m[COORD_W-1]) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
        end else if (m[COORD_W-1:COORD_W-10] == '0) begin
          a_q <= a_q << 8;
          b_q <= b_q << 8;
        end else if (!m[COORD_W-2]) begin
          a_q <= a_q << 1;
          b_q <= b_q << 1;
        end
      end
      F_DIVX: begin
        if (div_done) tx_q <= div_quo;
      end
      F_DIVY: begin
        if (div_done) ty_q <= div_quo;
      end
      F_TDONE: begin
        if (ph_q == PH_TPREV) tprev_q <= {ty_word, tx_word};
        else tn_q <= {ty_word, tx_word};
      end
      F_EMIT1: begin
        if (emit_go) begin
          if (fin_q) begin
            if (n_q == 2'd1) tn_q <= tprev_q;
          end else begin
            p2x_q <= p1x_q;
            p2y_q <= p1y_q;
            p1x_q <= px_q;
            p1y_q <= py_q;
            sl1_q <= sl0_q;
            sl0_q <= dn_q;
            ut1_q <= ut0_q;
            ut0_q <= tprev_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  `PCS_ASSERT_IMP(a_job_room, clk_i, rst_ni, job_push_o, !job_full_i, "job pushed into full queue")
  `PCS_ASSERT_NXT(a_accept_class, clk_i, rst_ni, in_acc, st_q == F_CLASS, "accepted point not classified")
  `PCS_ASSERT_IMP(a_emit_history, clk_i, rst_ni, st_q == F_EMIT1, n_q != 2'd0, "emit without history")

endmodule

`default_nettype wire

@@ design/pcs_back.sv @@
// Back end: turns curvature jobs into results (tangent difference magnitude,
// arc-step scaling, rounded division, saturation). Uses pcs_pkg, pcs_isqrt, pcs_div.
`default_nettype none
`include "polyline_curvature_stream_core_defines.svh"

module pcs_back
  import pcs_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int CURV_FRAC_BITS  = CURV_FRAC_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      job_empty_i,
  input  wire job_t      job_i,
  output logic           job_pop_o,
  output logic           res_push_o,
  output curv_res_t      res_o,
  input  wire logic      res_full_i
);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_SQX   = 4'd1;
  localparam logic [3:0] B_SQY   = 4'd2;
  localparam logic [3:0] B_SUM   = 4'd3;
  localparam logic [3:0] B_SQRT  = 4'd4;
  localparam logic [3:0] B_SCALE = 4'd5;
  localparam logic [3:0] B_CMP   = 4'd6;
  localparam logic [3:0] B_DIV   = 4'd7;
  localparam logic [3:0] B_OUT   = 4'd8;

  localparam int SH    = COORD_FRAC_BITS + CURV_FRAC_BITS - 30;
  localparam int SHL   = (SH > 0) ? SH : 0;
  localparam int SHR   = (SH < 0) ? -SH : 0;
  localparam int MAGW  = SQRT_IN_W / 2;
  localparam int DENW  = ARC_W + SHR;
  localparam int NUMW  = (((MAGW + SHL) > (DENW - 1)) ? (MAGW + SHL) : (DENW - 1)) + 1;
  localparam int CMPW  = DENW + CURV_W;
  localparam int EW    = TAN_W + 1;

  logic [3:0]               st_q;
  job_t                     job_q;
  logic signed [EW-1:0]     ex_q, ey_q;
  logic [2*TAN_W-1:0]       sqx_q, sqy_q;
  logic [MAGW-1:0]          mag_q;
  logic [NUMW-1:0]          num_q;
  logic [DENW-1:0]          dens_q;
  curv_res_t                res_q;

  logic signed [2*EW-1:0]   prod;
  logic [2*TAN_W:0]         e2;
  logic [DENW-1:0]          dens;
  logic                     sat;
  logic                     sq_start, sq_done;
  logic [MAGW-1:0]          sq_root;
  logic                     div_start, div_done;
  logic [CURV_W-1:0]        div_quo;

  assign job_pop_o  = (st_q == B_IDLE) && !job_empty_i;
  assign res_push_o = (st_q == B_OUT) && !res_full_i;
  assign res_o      = res_q;
  assign prod       = (st_q == B_SQX) ? ex_q * ex_q : ey_q * ey_q;
  assign e2         = (2*TAN_W+1)'(sqx_q) + (2*TAN_W+1)'(sqy_q);
  assign dens       = DENW'(job_q.arc_step) << SHR;
  assign sat        = CMPW'(num_q) >= {dens_q, CURV_W'(0)};
  assign sq_start   = st_q == B_SUM;
  assign div_start  = (st_q == B_CMP) && !sat;

  pcs_isqrt #(
    .W(SQRT_IN_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .op_i   ({e2[2*TAN_W-1:0], (SQRT_IN_W/2)'(0)}),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  pcs_div #(
    .NW(NUMW),
    .DW(DENW),
    .QW(CURV_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (dens_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
    end else begin
      unique case (st_q)
        B_IDLE: begin
          if (job_pop_o) st_q <= job_i.single ? B_OUT : B_SQX;
        end
        B_SQX: st_q <= B_SQY;
        B_SQY: st_q <= B_SUM;
        B_SUM: st_q <= B_SQRT;
        B_SQRT: begin
          if (sq_done) st_q <= (job_q.arc_step == '0) ? B_OUT : B_SCALE;
        end
        B_SCALE: st_q <= B_CMP;
        B_CMP: st_q <= sat ? B_OUT : B_DIV;
        B_DIV: begin
          if (div_done) st_q <= B_OUT;
        end
        B_OUT: begin
          if (!res_full_i) st_q <= B_IDLE;
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      B_IDLE: begin
        if (job_pop_o) begin
          job_q <= job_i;
          ex_q  <= EW'($signed(job_i.tan_b[TAN_W-1:0])) -
                   EW'($signed(job_i.tan_a[TAN_W-1:0]));
          ey_q  <= EW'($signed(job_i.tan_b[2*TAN_W-1:TAN_W])) -
                   EW'($signed(job_i.tan_a[2*TAN_W-1:TAN_W]));
          res_q <= '{curvature: '0, final_result: 1'b1, status: ST_SINGLE};
        end
      end
      B_SQX: sqx_q <= prod[2*TAN_W-1:0];
      B_SQY: sqy_q <= prod[2*TAN_W-1:0];
      B_SQRT: begin
        if (sq_done) begin
          mag_q <= sq_root;
          res_q <= '{curvature: CURV_MAX, final_result: job_q.final_result,
                     status: ST_ZERO_STEP};
        end
      end
      B_SCALE: begin
        num_q  <= (NUMW'(mag_q) << SHL) + NUMW'(dens >> 1);
        dens_q <= dens;
      end
      B_CMP: begin
        res_q <= '{curvature: CURV_MAX, final_result: job_q.final_result, status: ST_OK};
      end
      B_DIV: begin
        if (div_done) begin
          res_q <= '{curvature: div_quo, final_result: job_q.final_result, status: ST_OK};
        end
      end
      default: begin
      end
    endcase
  end

  `PCS_ASSERT_IMP(a_res_room, clk_i, rst_ni, res_push_o, !res_full_i, "result pushed into full queue")
  `PCS_ASSERT_IMP(a_zero_sat, clk_i, rst_ni, res_push_o && (res_o.status == ST_ZERO_STEP), res_o.curvature == CURV_MAX, "zero arc step not saturated")
  `PCS_ASSERT_NXT(a_pop_busy, clk_i, rst_ni, job_pop_o, st_q != B_IDLE, "job taken but back end idle")

endmodule

`default_nettype wire

@@ design/polyline_curvature_stream_core.sv @@
// Top level of the polyline curvature stream core: front end, job queue,
// back end and result queue. Uses pcs_pkg, pcs_front, pcs_back and pcs_fifo.
`default_nettype none

// Points enter through a push/full port and curvature results leave through an
// empty/pop port. The front end takes one point at a time: it computes the segment
// length with its 32-step square root (saturating when the squared sum overflows),
// then each nonzero unit tangent with normalizing shifts, a 32-step square root and
// two 15-step divisions (a zero difference skips these); a last point computes one
// more tangent. The back end computes a result with its 32-step square root and,
// unless it saturates, a 24-step division, and runs in parallel behind a job queue.
// Results come out two points late, and the last point of a polyline releases the
// remaining ones in point order.
module polyline_curvature_stream_core
  import pcs_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int CURV_FRAC_BITS  = CURV_FRAC_BITS_DEF,
  parameter int JOB_DEPTH       = JOB_DEPTH_DEF,
  parameter int RES_DEPTH       = RES_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire point_req_t point_i,
  output logic            empty,
  input  wire logic       pop,
  output curv_res_t       result_o
);

  logic      job_push, job_full, job_empty, job_pop;
  job_t      job_in, job_out;
  logic      res_push, res_full;
  curv_res_t res_in;

  pcs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .point_i   (point_i),
    .job_push_o(job_push),
    .job_o     (job_in),
    .job_full_i(job_full)
  );

  pcs_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(JOB_DEPTH)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .data_o (job_out),
    .empty_o(job_empty)
  );

  pcs_back #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .CURV_FRAC_BITS (CURV_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  pcs_fifo #(
    .WIDTH($bits(curv_res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (result_o),
    .empty_o(empty)
  );

endmodule

`default_nettype wire
